[src/rdsc_pkg.sv]
// Shared codes, constants and controller/datapath command type for the rover control unit.
package rdsc_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_LOST = 2'd2;

  // Event codes reported with every result
  localparam logic [3:0] EV_F       = 4'd0;
  localparam logic [3:0] EV_B       = 4'd1;
  localparam logic [3:0] EV_L       = 4'd2;
  localparam logic [3:0] EV_R       = 4'd3;
  localparam logic [3:0] EV_Q       = 4'd4;
  localparam logic [3:0] EV_E       = 4'd5;
  localparam logic [3:0] EV_Z       = 4'd6;
  localparam logic [3:0] EV_C       = 4'd7;
  localparam logic [3:0] EV_S       = 4'd8;
  localparam logic [3:0] EV_X       = 4'd9;
  localparam logic [3:0] EV_Y       = 4'd10;
  localparam logic [3:0] EV_UNKNOWN = 4'd11;
  localparam logic [3:0] EV_SPACE   = 4'd12;
  localparam logic [3:0] EV_TICK    = 4'd13;
  localparam logic [3:0] EV_STOP    = 4'd14;

  // Drive direction
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_STEP_INTERVAL = 3'd0;
  localparam logic [2:0] CFG_STEP_SIZE     = 3'd1;
  localparam logic [2:0] CFG_LEFT_LIMIT    = 3'd2;
  localparam logic [2:0] CFG_RIGHT_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_PWM_MIN       = 3'd4;
  localparam logic [2:0] CFG_PWM_MAX       = 3'd5;

  // Configuration reset values
  localparam logic [9:0]  RST_STEP_INTERVAL = 10'd30;
  localparam logic [6:0]  RST_STEP_SIZE     = 7'd1;
  localparam logic [6:0]  RST_LEFT_LIMIT    = 7'd35;
  localparam logic [6:0]  RST_RIGHT_LIMIT   = 7'd55;
  localparam logic [11:0] RST_PWM_MIN       = 12'd205;
  localparam logic [11:0] RST_PWM_MAX       = 12'd410;

  localparam logic [6:0] MaxLimit = 7'd90;

  // Wheel geometry: center angles, order FR, FL, RR, RL
  localparam logic [8:0] CenterFr = 9'd75;
  localparam logic [8:0] CenterFl = 9'd125;
  localparam logic [8:0] CenterRr = 9'd35;
  localparam logic [8:0] CenterRl = 9'd70;
  localparam logic [8:0] AngleMax = 9'd180;

  // Right-turn gains, one divider lane each (the 55 lane serves FR and RL)
  localparam int unsigned NumLanes = 3;
  localparam logic [5:0] RightGain [NumLanes] = '{6'd55, 6'd50, 6'd23};

  // Right scaling divider: quotient never exceeds the largest gain
  localparam int unsigned QuoW = 6;
  localparam int unsigned RemW = 14;

  // x/180 = (x>>2)/45, and (y/45) = (y*Recip45) >> Recip45Shift for y < 2^18
  localparam logic [24:0] Recip45      = 25'd23860930;
  localparam int unsigned Recip45Shift = 30;

  localparam int unsigned NumWheels = 4;

  typedef struct packed {
    logic       take;      // input request accepted this edge
    logic       prep;      // load divider lanes
    logic       div_step;  // one quotient bit
    logic [2:0] div_idx;   // quotient bit being resolved
    logic       mul1;      // angles times PWM span
    logic       mul2;      // divide by 180
    logic       load;      // write output register
  } rdsc_cmd_t;

endpackage

[src/rdsc_ctrl.sv]
// Sequencer for the rover control unit: handshakes and datapath command generation.
module rdsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output rdsc_pkg::rdsc_cmd_t cmd_o
);
  import rdsc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;

  localparam logic [2:0] DivTop = 3'(QuoW - 1);

  logic [2:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       take, load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == ST_LOAD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = ST_PREP;
      ST_PREP: begin
        idx_d   = DivTop;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (idx_q == 3'd0) begin
          state_d = ST_MUL1;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_LOAD;
      ST_LOAD: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = take;
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.div_idx  = idx_q;
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.load     = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/rdsc_datapath.sv]
// Datapath: config registers, command decode, steering ramp, right scaling divider, PWM mapping.
module rdsc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdsc_pkg::rdsc_cmd_t cmd_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          command_byte_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i,
  output logic [63:0]         out_data_o,
  output logic [3:0]          out_user_o
);
  import rdsc_pkg::*;

  // Configuration
  logic [9:0]  interval_q;
  logic [6:0]  step_q, left_q, right_q;
  logic [11:0] pwm_min_q, pwm_max_q;

  // Control state
  logic signed [7:0] tgt_q, tgt_d, cur_q, cur_d;
  logic [9:0]        elapsed_q, elapsed_d;
  logic [1:0]        drive_q, drive_d;
  logic              pump_q, pump_d;
  logic [3:0]        code_q, code_d;
  logic              moved_q, moved_d;

  // Decode
  logic [7:0] up_c;
  logic [3:0] cmd_code;
  logic [6:0] eff_left, eff_right;
  logic signed [7:0] left_tgt, right_tgt;

  // Ramp
  logic signed [9:0] cur_x, tgt_x, up_sum, dn_sum;
  logic signed [7:0] ramp_val;
  logic [9:0]        el_inc;

  // Divider lanes
  logic [RemW-1:0] rem_q [NumLanes];
  logic [QuoW-1:0] quo_q [NumLanes];
  logic [7:0]      den_q;
  logic [6:0]      m_val;
  logic [RemW-1:0] num   [NumLanes];
  logic [RemW-1:0] trial;

  // PWM mapping
  logic signed [12:0] span;
  logic [11:0]        span_mag;
  logic [6:0]         e_mag;
  logic signed [9:0]  angle_s [NumWheels];
  logic [7:0]         angle   [NumWheels];
  logic [19:0]        prod_q  [NumWheels];
  logic [42:0]        wide    [NumWheels];
  logic [11:0]        q180_q  [NumWheels];
  logic [11:0]        pulse   [NumWheels];

  logic [63:0] out_data_q;
  logic [3:0]  out_user_q;

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= RST_STEP_INTERVAL;
      step_q     <= RST_STEP_SIZE;
      left_q     <= RST_LEFT_LIMIT;
      right_q    <= RST_RIGHT_LIMIT;
      pwm_min_q  <= RST_PWM_MIN;
      pwm_max_q  <= RST_PWM_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP_INTERVAL: interval_q <= cfg_data_i[9:0];
        CFG_STEP_SIZE:     step_q     <= cfg_data_i[6:0];
        CFG_LEFT_LIMIT:    left_q     <= cfg_data_i[6:0];
        CFG_RIGHT_LIMIT:   right_q    <= cfg_data_i[6:0];
        CFG_PWM_MIN:       pwm_min_q  <= cfg_data_i;
        CFG_PWM_MAX:       pwm_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_left  = (left_q > MaxLimit) ? MaxLimit : left_q;
  assign eff_right = (right_q == 7'd0) ? 7'd1 : ((right_q > MaxLimit) ? MaxLimit : right_q);
  assign left_tgt  = -$signed({1'b0, eff_left});
  assign right_tgt = $signed({1'b0, eff_right});

  // ---------------- command decode ----------------
  always_comb begin
    up_c = command_byte_i;
    if (command_byte_i >= 8'h61 && command_byte_i <= 8'h7a) up_c = command_byte_i - 8'h20;
  end

  always_comb begin
    unique case (up_c)
      8'h0d, 8'h0a, 8'h20: cmd_code = EV_SPACE;
      8'h46: cmd_code = EV_F;
      8'h42: cmd_code = EV_B;
      8'h4c: cmd_code = EV_L;
      8'h52: cmd_code = EV_R;
      8'h51: cmd_code = EV_Q;
      8'h45: cmd_code = EV_E;
      8'h5a: cmd_code = EV_Z;
      8'h43: cmd_code = EV_C;
      8'h53: cmd_code = EV_S;
      8'h58: cmd_code = EV_X;
      8'h59: cmd_code = EV_Y;
      default: cmd_code = EV_UNKNOWN;
    endcase
  end

  // ---------------- steering ramp ----------------
  always_comb begin
    cur_x  = 10'(cur_q);
    tgt_x  = 10'(tgt_q);
    up_sum = cur_x + $signed({3'b000, step_q});
    dn_sum = cur_x - $signed({3'b000, step_q});
    if (cur_q < tgt_q) begin
      ramp_val = (up_sum > tgt_x) ? tgt_q : up_sum[7:0];
    end else if (cur_q > tgt_q) begin
      ramp_val = (dn_sum < tgt_x) ? tgt_q : dn_sum[7:0];
    end else begin
      ramp_val = cur_q;
    end
    el_inc = elapsed_q + 10'd1;
  end

  // ---------------- next state per item ----------------
  always_comb begin
    tgt_d     = tgt_q;
    cur_d     = cur_q;
    elapsed_d = elapsed_q;
    drive_d   = drive_q;
    pump_d    = pump_q;
    moved_d   = 1'b0;
    code_d    = EV_UNKNOWN;
    unique case (kind_i)
      KIND_CMD: begin
        code_d = cmd_code;
        unique case (cmd_code)
          EV_F: begin tgt_d = '0;        drive_d = DIR_FWD;  end
          EV_B: begin tgt_d = '0;        drive_d = DIR_BACK; end
          EV_L: begin tgt_d = left_tgt;  drive_d = DIR_STOP; end
          EV_R: begin tgt_d = right_tgt; drive_d = DIR_STOP; end
          EV_Q: begin tgt_d = left_tgt;  drive_d = DIR_FWD;  end
          EV_E: begin tgt_d = right_tgt; drive_d = DIR_FWD;  end
          EV_Z: begin tgt_d = left_tgt;  drive_d = DIR_BACK; end
          EV_C: begin tgt_d = right_tgt; drive_d = DIR_BACK; end
          EV_S: begin tgt_d = '0;        drive_d = DIR_STOP; pump_d = 1'b0; end
          EV_X: pump_d = 1'b1;
          EV_Y: pump_d = 1'b0;
          default: ;
        endcase
      end
      KIND_TICK: begin
        code_d    = EV_TICK;
        elapsed_d = el_inc;
        if (el_inc >= interval_q) begin
          elapsed_d = '0;
          cur_d     = ramp_val;
          moved_d   = (ramp_val != cur_q);
        end
      end
      KIND_LOST: begin
        code_d  = EV_STOP;
        tgt_d   = '0;
        drive_d = DIR_STOP;
        pump_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q     <= '0;
      cur_q     <= '0;
      elapsed_q <= '0;
      drive_q   <= DIR_STOP;
      pump_q    <= 1'b0;
      code_q    <= EV_UNKNOWN;
      moved_q   <= 1'b0;
    end else if (cmd_i.take) begin
      tgt_q     <= tgt_d;
      cur_q     <= cur_d;
      elapsed_q <= elapsed_d;
      drive_q   <= drive_d;
      pump_q    <= pump_d;
      code_q    <= code_d;
      moved_q   <= moved_d;
    end
  end

  // ---------------- right scaling: (2*g*m + R) / (2R), one bit per cycle ----------------
  always_comb begin
    m_val = '0;
    if (!cur_q[7]) m_val = (cur_q[6:0] < eff_right) ? cur_q[6:0] : eff_right;
    for (int k = 0; k < NumLanes; k++) begin
      num[k] = RemW'({RightGain[k], 1'b0}) * RemW'(m_val) + RemW'(eff_right);
    end
    trial = RemW'({6'b0, den_q}) << cmd_i.div_idx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      den_q <= {eff_right, 1'b0};
      for (int k = 0; k < NumLanes; k++) begin
        rem_q[k] <= num[k];
        quo_q[k] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < NumLanes; k++) begin
        if (rem_q[k] >= trial) begin
          rem_q[k]                <= rem_q[k] - trial;
          quo_q[k][cmd_i.div_idx] <= 1'b1;
        end
      end
    end
  end

  // ---------------- wheel angles and PWM counts ----------------
  assign span     = $signed({1'b0, pwm_max_q}) - $signed({1'b0, pwm_min_q});
  assign span_mag = span[12] ? 12'(-span) : span[11:0];
  assign e_mag    = 7'(-cur_q);

  always_comb begin
    if (cur_q[7]) begin
      angle_s[0] = $signed({1'b0, CenterFr}) - $signed({3'b0, e_mag});
      angle_s[1] = $signed({1'b0, CenterFl}) - $signed({3'b0, e_mag});
      angle_s[2] = $signed({1'b0, CenterRr}) + $signed({3'b0, e_mag});
      angle_s[3] = $signed({1'b0, CenterRl}) + $signed({3'b0, e_mag});
    end else begin
      angle_s[0] = $signed({1'b0, CenterFr}) + $signed({4'b0, quo_q[0]});
      angle_s[1] = $signed({1'b0, CenterFl}) + $signed({4'b0, quo_q[1]});
      angle_s[2] = $signed({1'b0, CenterRr}) - $signed({4'b0, quo_q[2]});
      angle_s[3] = $signed({1'b0, CenterRl}) - $signed({4'b0, quo_q[0]});
    end
    for (int w = 0; w < NumWheels; w++) begin
      if (angle_s[w] < 0) begin
        angle[w] = '0;
      end else if (angle_s[w] > $signed({1'b0, AngleMax})) begin
        angle[w] = AngleMax[7:0];
      end else begin
        angle[w] = angle_s[w][7:0];
      end
      wide[w]  = {25'b0, prod_q[w][19:2]} * {18'b0, Recip45};
      pulse[w] = span[12] ? (pwm_min_q - q180_q[w]) : (pwm_min_q + q180_q[w]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < NumWheels; w++) begin
      if (cmd_i.mul1) prod_q[w] <= {12'b0, angle[w]} * {8'b0, span_mag};
      if (cmd_i.mul2) q180_q[w] <= wide[w][Recip45Shift+11:Recip45Shift];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {4'b0, pulse[3], pulse[2], pulse[1], pulse[0],
                     moved_q, cur_q, pump_q, drive_q};
      out_user_q <= code_q;
    end
  end

endmodule

[src/rover_drive_and_steering_control_unit.sv]
// Top level of the rover drive and steering control unit.
//
// Input stream: s_axis_tuser carries the item kind (command byte, 1 ms tick,
// link lost), s_axis_tdata the command byte. Output stream: one result per
// request, drive/pump state, steering offset and four servo PWM counts in
// m_axis_tdata, event code in m_axis_tuser.
// Config channel: cfg_index_i selects the register, cfg_data_i holds the
// value (low bits used); always ready, write only while the unit is idle.
// Sequence: an accepted request passes through a prepare state, the radix-2
// divider that scales the right-turn offset, two multiply stages for the PWM
// mapping and the output load; a new request is taken only once the unit is
// back in idle after that load.
// The output register holds a finished result while the receiver stalls;
// the next request may be taken meanwhile, but its result waits until the
// register is free.
// Reset: registers return to their defaults, offset, target, tick counter,
// drive and pump clear, and no result is pending.
module rover_drive_and_steering_control_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] command_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [1:0] motor_dir, [2] pump_on, [10:3] steer_offset,
                                      // [11] servo_moved, [23:12] pulse_front_right,
                                      // [35:24] pulse_front_left, [47:36] pulse_rear_right,
                                      // [59:48] pulse_rear_left, [63:60] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] event_code
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import rdsc_pkg::*;

  rdsc_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rdsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  rdsc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (s_axis_tuser),
    .command_byte_i (s_axis_tdata),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_data_o     (m_axis_tdata),
    .out_user_o     (m_axis_tuser)
  );

endmodule
